// ===== hw/rtl/vn_pkg.sv =====
// Shared constants and helpers for the vector normalize block.
package vn_pkg;

    // Default parameter values
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 14;

    // Fixed output field widths
    localparam int UNIT_W = 16;
    localparam int LEN_W  = 16;
    localparam int OUT_W  = 3 * UNIT_W + LEN_W;

    // Signed unit component from a quotient magnitude, masked to the field
    function automatic logic [UNIT_W-1:0] to_unit(input logic [31:0] quo, input logic neg);
        logic [31:0] v;
        v = neg ? (32'd0 - quo) : quo;
        return v[UNIT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/vec3_normalize.sv =====
// Top level: length and unit direction of a three-component vector.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------------
//  s (in)   | in  | i_s_tvalid / o_s_tready | comp_x, comp_y, comp_z
//  m (out)  | out | o_m_tvalid / i_m_tready | unit_x, unit_y, unit_z, length; zero
//
// One vector per cycle while the output is not held. Stages in order: three front
// stages (magnitude, squares, sum), one square root cell per root bit, one divider
// cell per quotient bit, and the output register.
// Synchronous active-low reset clears only the valid bits. When the output is
// held the whole chain freezes; bubbles are filled while the output is empty.
module vec3_normalize #(
    parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = vn_pkg::FRACTION_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_s_tvalid,
    output logic                                         o_s_tready,
    // comp_x, comp_y, comp_z from bit 0 up, zero filled to bytes
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0]        i_s_tdata,
    output logic                                         o_m_tvalid,
    input  logic                                         i_m_tready,
    // unit_x, unit_y, unit_z, length from bit 0 up
    output logic [vn_pkg::OUT_W-1:0]                     o_m_tdata,
    // zero_vector
    output logic                                         o_m_tuser
);
    import vn_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int SW     = 2 * CB;
    localparam int QW     = FRACTION_BITS + 1;
    localparam int SIDE_S = 3 * CB + 4;
    localparam int NV     = 4 + CB + QW;

    logic          w_en;
    logic [NV-1:0] r_vld;

    // Front stage registers
    logic [CB-1:0] r_mag0 [3];
    logic [2:0]    r_neg0;
    logic [SW-1:0] r_sq1  [3];
    logic [CB-1:0] r_mag1 [3];
    logic [2:0]    r_neg1;
    logic [SW-1:0] r_sum2;
    logic          r_zero2;
    logic [CB-1:0] r_mag2 [3];
    logic [2:0]    r_neg2;

    // Chain wires
    logic [SW-1:0]     w_rad  [CB+1];
    logic [CB+1:0]     w_srem [CB+1];
    logic [CB-1:0]     w_root [CB+1];
    logic [SIDE_S-1:0] w_sside[CB+1];

    logic [CB-1:0] w_dlen [3][QW+1];
    logic [CB-1:0] w_drem [3][QW+1];
    logic [QW-1:0] w_quo  [3][QW+1];
    logic [1:0]    w_dside[3][QW+1];

    // Output registers
    logic [UNIT_W-1:0] r_unit [3];
    logic [LEN_W-1:0]  r_len;
    logic              r_zero;
    logic [31:0]       w_len_ext;

    assign w_en       = !r_vld[NV-1] || i_m_tready;
    assign o_s_tready = w_en;

    // Valid bits along the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_s_tvalid};
        end
    end

    // Magnitude, squares and sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                logic [CB-1:0] c;
                c          = i_s_tdata[i*CB +: CB];
                r_neg0[i]  <= c[CB-1];
                r_mag0[i]  <= c[CB-1] ? (~c + 1'b1) : c;
                r_sq1[i]   <= {{CB{1'b0}}, r_mag0[i]} * {{CB{1'b0}}, r_mag0[i]};
                r_mag1[i]  <= r_mag0[i];
                r_mag2[i]  <= r_mag1[i];
            end
            r_neg1  <= r_neg0;
            r_neg2  <= r_neg1;
            r_sum2  <= r_sq1[0] + r_sq1[1] + r_sq1[2];
            r_zero2 <= (r_sq1[0] == '0) && (r_sq1[1] == '0) && (r_sq1[2] == '0);
        end
    end

    // Square root chain: one cell per root bit
    assign w_rad[0]   = r_sum2;
    assign w_srem[0]  = '0;
    assign w_root[0]  = '0;
    assign w_sside[0] = {r_zero2, r_neg2, r_mag2[2], r_mag2[1], r_mag2[0]};

    for (genvar k = 0; k < CB; k++) begin : g_sqrt
        vn_sqrt_cell #(.CB(CB), .SIDE_W(SIDE_S)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_rad[k]),
            .i_rem  (w_srem[k]),
            .i_root (w_root[k]),
            .i_side (w_sside[k]),
            .o_rad  (w_rad[k+1]),
            .o_rem  (w_srem[k+1]),
            .o_root (w_root[k+1]),
            .o_side (w_sside[k+1])
        );
    end

    // Divider chains: one lane per component, one cell per quotient bit
    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_dlen[l][0]  = w_root[CB];
        assign w_drem[l][0]  = w_sside[CB][l*CB +: CB];
        assign w_quo[l][0]   = '0;
        assign w_dside[l][0] = {w_sside[CB][SIDE_S-1], w_sside[CB][3*CB+l]};
        for (genvar k = 0; k < QW; k++) begin : g_div
            vn_div_cell #(.CB(CB), .QW(QW), .SHIFT(k != 0)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_len  (w_dlen[l][k]),
                .i_rem  (w_drem[l][k]),
                .i_quo  (w_quo[l][k]),
                .i_side (w_dside[l][k]),
                .o_len  (w_dlen[l][k+1]),
                .o_rem  (w_drem[l][k+1]),
                .o_quo  (w_quo[l][k+1]),
                .o_side (w_dside[l][k+1])
            );
        end
    end

    // Output register: sign restore, zero vector forced to zeros
    assign w_len_ext = 32'(w_dlen[0][QW]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_unit[i] <= w_dside[0][QW][1] ? '0 :
                             to_unit(32'(w_quo[i][QW]), w_dside[i][QW][0]);
            end
            r_len  <= w_dside[0][QW][1] ? '0 : w_len_ext[LEN_W-1:0];
            r_zero <= w_dside[0][QW][1];
        end
    end

    assign o_m_tvalid = r_vld[NV-1];
    assign o_m_tdata  = {r_len, r_unit[2], r_unit[1], r_unit[0]};
    assign o_m_tuser  = r_zero;

endmodule

// ===== hw/rtl/vn_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module vn_sqrt_cell #(
    parameter int CB     = vn_pkg::COMPONENT_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [2*CB-1:0]     i_rad,
    input  logic [CB+1:0]       i_rem,
    input  logic [CB-1:0]       i_root,
    input  logic [SIDE_W-1:0]   i_side,
    output logic [2*CB-1:0]     o_rad,
    output logic [CB+1:0]       o_rem,
    output logic [CB-1:0]       o_root,
    output logic [SIDE_W-1:0]   o_side
);
    import vn_pkg::*;

    logic [CB+3:0] w_trem;
    logic [CB+3:0] w_trial;
    logic          w_ge;
    logic [CB+3:0] w_diff;

    // Bring down two radicand bits and try root*4+1
    assign w_trem  = {i_rem, i_rad[2*CB-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_trem >= w_trial);
    assign w_diff  = w_ge ? (w_trem - w_trial) : w_trem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[2*CB-3:0], 2'b00};
            o_rem  <= w_diff[CB+1:0];
            o_root <= {i_root[CB-2:0], w_ge};
            o_side <= i_side;
        end
    end

endmodule

// ===== hw/rtl/vn_div_cell.sv =====
// One quotient bit cell of the pipelined restoring divider chain.
module vn_div_cell #(
    parameter int CB    = vn_pkg::COMPONENT_BITS_DEF,
    parameter int QW    = vn_pkg::FRACTION_BITS_DEF + 1,
    parameter bit SHIFT = 1'b1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [CB-1:0]   i_len,
    input  logic [CB-1:0]   i_rem,
    input  logic [QW-1:0]   i_quo,
    input  logic [1:0]      i_side,
    output logic [CB-1:0]   o_len,
    output logic [CB-1:0]   o_rem,
    output logic [QW-1:0]   o_quo,
    output logic [1:0]      o_side
);
    import vn_pkg::*;

    logic [CB:0] w_t;
    logic [CB:0] w_d;
    logic        w_ge;
    logic [CB:0] w_r;

    // Shift partial remainder (except in the first cell) and subtract if it fits
    assign w_t  = SHIFT ? {i_rem, 1'b0} : {1'b0, i_rem};
    assign w_d  = {1'b0, i_len};
    assign w_ge = (w_t >= w_d);
    assign w_r  = w_ge ? (w_t - w_d) : w_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_len  <= i_len;
            o_rem  <= w_r[CB-1:0];
            o_quo  <= {i_quo[QW-2:0], w_ge};
            o_side <= i_side;
        end
    end

endmodule

// ===== hw/rtl/vn_checker.sv =====
// Port-level assertions for the vector normalize block, with its bind.
module vn_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_s_tready,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [vn_pkg::OUT_W-1:0] o_m_tdata,
    input logic                     o_m_tuser
);
    import vn_pkg::*;

    // Output is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // Empty output never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // Zero vector gives an all-zero payload
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("zero vector with nonzero payload");

    // A nonzero vector has a nonzero length
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[OUT_W-1 -: LEN_W] != '0)
        else $error("nonzero vector with zero length");

endmodule

bind vec3_normalize vn_checker u_vn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== bench/vec3_normalize_test.sv =====
// Stimulus, prediction and checking for the vector normalize block.
module vec3_normalize_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB       = vn_pkg::COMPONENT_BITS_DEF;
    localparam int FB       = vn_pkg::FRACTION_BITS_DEF;
    localparam int IN_W     = ((3*CB+7)/8)*8;
    localparam int N_RANDOM = 950;
    localparam int WD_LIMIT = 5000;
    localparam int DRAIN    = 4 + CB + FB + 1 + 20;

    typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH, PH_HOLD} t_phase;

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic [15:0] len;
        logic        zero;
    } t_norm;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        bit                   typed;
        t_norm                want;
    } t_vec_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [63:0]     o_m_tdata;
    logic            o_m_tuser;

    t_norm  pending_norms[$];
    t_phase phase = PH_FREE;
    int     mismatches = 0;
    int     quiet_cycles = 0;

    vec3_normalize u_dut (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Floor square root by setting result bits from the top down
    function automatic logic [63:0] floor_root(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    // Expected length and unit vector of one input vector
    function automatic t_norm predict_norm(input logic signed [CB-1:0] x,
                                           input logic signed [CB-1:0] y,
                                           input logic signed [CB-1:0] z);
        t_norm       n;
        logic [63:0] mag[3];
        logic        neg[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic signed [CB-1:0] c[3];
        logic [15:0] u[3];
        c[0] = x; c[1] = y; c[2] = z;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i][CB-1];
            mag[i] = neg[i] ? 64'(-(65'(c[i]))) : 64'(c[i]);
            sum += mag[i] * mag[i];
        end
        n = '0;
        if (sum == 0) begin
            n.zero = 1'b1;
            return n;
        end
        len = floor_root(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << FB) / len;
            if (q > (64'd1 << FB)) q = 64'd1 << FB;
            if (neg[i]) q = 64'd0 - q;
            u[i] = q[15:0];
        end
        n.ux = u[0]; n.uy = u[1]; n.uz = u[2];
        n.len = len[15:0];
        return n;
    endfunction

    // Idle chance in percent for the current phase
    function automatic int src_idle_pct();
        case (phase)
            PH_SRC_IDLE: return 74;
            PH_BOTH:     return 38;
            default:     return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (phase)
            PH_SINK_STALL: return 74;
            PH_BOTH:       return 38;
            default:       return 0;
        endcase
    endfunction

    // Offer one vector and hold it until the transaction completes
    task automatic send_vector(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                               input logic signed [CB-1:0] z, input bit typed,
                               input t_norm want);
        t_norm n;
        if ($urandom_range(99) < src_idle_pct()) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct());
        end
        i_s_tdata  <= {x, y, z} == '0 ? '0 : IN_W'({z, y, x});
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        n = typed ? want : predict_norm(x, y, z);
        pending_norms.push_back(n);
    endtask

    // Result side: check each transaction, then pick the next ready value
    always @(posedge i_clk) begin
        t_norm got;
        t_norm exp_n;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32],
                   o_m_tdata[63:48], o_m_tuser};
            if (pending_norms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_n = pending_norms.pop_front();
                if (got !== exp_n) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp ux=%h uy=%h uz=%h len=%h zero=%b,",
                                  " got ux=%h uy=%h uz=%h len=%h zero=%b"},
                                 exp_n.ux, exp_n.uy, exp_n.uz, exp_n.len, exp_n.zero,
                                 got.ux, got.uy, got.uz, got.len, got.zero);
                end
            end
        end
        if (phase == PH_HOLD) i_m_tready <= 1'b0;
        else i_m_tready <= ($urandom_range(99) >= sink_stall_pct());
    end

    // Long hold-off on the result side so the pipeline fills and backs up
    initial begin
        wait (phase == PH_HOLD);
        repeat (300) @(posedge i_clk);
        phase = PH_BOTH;
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Pick a random vector, weighted toward small and edge values
    task automatic random_vector(output logic signed [CB-1:0] v[3]);
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 3; i++) begin
            case (kind)
                0, 1:    v[i] = CB'($signed($urandom_range(8)) - 4);
                2:       v[i] = ($urandom_range(1)) ? 16'sh8000 : 16'sh7fff;
                3:       v[i] = ($urandom_range(2) == 0) ? CB'($urandom) : '0;
                default: v[i] = CB'($urandom);
            endcase
        end
    endtask

    initial begin
        t_vec_row             rows[$];
        logic signed [CB-1:0] v[3];
        rows = '{
            '{0, 0, 0, 1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
            '{32767, 0, 0, 1, '{16'd16384, 16'd0, 16'd0, 16'd32767, 1'b0}},
            '{-32768, 0, 0, 1, '{16'hc000, 16'd0, 16'd0, 16'd32768, 1'b0}},
            '{0, 32767, 0, 1, '{16'd0, 16'd16384, 16'd0, 16'd32767, 1'b0}},
            '{0, 0, -32768, 1, '{16'd0, 16'd0, 16'hc000, 16'd32768, 1'b0}},
            '{1, 0, 0, 1, '{16'd16384, 16'd0, 16'd0, 16'd1, 1'b0}},
            '{0, -1, 0, 1, '{16'd0, 16'hc000, 16'd0, 16'd1, 1'b0}},
            '{1, 1, 0, 1, '{16'd16384, 16'd16384, 16'd0, 16'd1, 1'b0}},
            '{-1, -1, -1, 1, '{16'hc000, 16'hc000, 16'hc000, 16'd1, 1'b0}},
            '{-32768, -32768, -32768, 0, '0},
            '{32767, 32767, 32767, 0, '0},
            '{32767, -32768, 32767, 0, '0},
            '{3, 4, 0, 0, '0},
            '{2, 3, 6, 0, '0},
            '{-100, 200, -300, 0, '0},
            '{1, 2, 2, 0, '0},
            '{0, 0, 1, 0, '0},
            '{-21846, 21845, 5461, 0, '0}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) phase = PH_SRC_IDLE;
            if (n == 400) phase = PH_SINK_STALL;
            if (n == 600) phase = PH_BOTH;
            if (n == 750) phase = PH_HOLD;
            random_vector(v);
            send_vector(v[0], v[1], v[2], 0, '0);
        end
        i_s_tvalid <= 1'b0;
        phase = PH_FREE;

        while (pending_norms.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && pending_norms.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
